### hw/rtl/sbm_pkg.sv
package sbm_pkg;

	// bus command codes, also the active sequence
	typedef enum logic [2:0] {
		OP_IDLE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_NOACK = 3'd3,
		OP_WRITE = 3'd4,
		OP_READ  = 3'd5
	} op_t;

	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE + 1);
	localparam int STEP_W        = 3;
	localparam int TICK_W        = 16;
	localparam int CFG_IDX_W     = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TICKS   = 2'd1;

	localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 16'd100;
	localparam logic [TICK_W-1:0] ACK_TICKS_RST   = 16'd1000;

	// sequencer state
	typedef struct packed {
		op_t                      op;
		logic [STEP_W-1:0]        step;
		logic [BIT_IDX_W-1:0]     bit_idx;
		logic [BITS_PER_BYTE-1:0] shreg;
		logic                     scl;
		logic                     sda;
		logic                     oe;
		logic                     ack;
		logic [BITS_PER_BYTE-1:0] rbyte;
	} state_t;

	// one result beat
	typedef struct packed {
		logic                     scl;
		logic                     sda_out;
		logic                     sda_oe;
		logic                     busy_res;
		logic                     done_res;
		logic [BITS_PER_BYTE-1:0] rx_byte;
		logic                     acked;
	} res_t;

	// effective wait lengths from the configuration
	typedef struct packed {
		logic [TICK_W-1:0] phase;
		logic [TICK_W-1:0] ack;
	} waits_t;

endpackage

### hw/rtl/sbm_tick_if.sv
interface sbm_tick_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [7:0] tx_byte;
	logic       sda_in;

	modport source (output valid, output cmd, output tx_byte, output sda_in, input ready);
	modport sink (input valid, input cmd, input tx_byte, input sda_in, output ready);
endinterface

### hw/rtl/sbm_result_if.sv
interface sbm_result_if;
	logic       valid;
	logic       ready;
	logic       scl;
	logic       sda_out;
	logic       sda_oe;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       acked;

	modport source (
		output valid, output scl, output sda_out, output sda_oe, output busy_res,
		output done_res, output rx_byte, output acked, input ready
	);
	modport sink (
		input valid, input scl, input sda_out, input sda_oe, input busy_res,
		input done_res, input rx_byte, input acked, output ready
	);
endinterface

### hw/rtl/sbm_cfg_if.sv
interface sbm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/sccb_bit_master_unit.sv
// Bit-level master for the camera control bus (three-wire, I2C-like). Each beat on
// tick is one time tick: an optional command (start, stop, no-ack, write byte,
// read byte) plus the sampled data line. Every tick yields exactly one result beat
// with the driven clock and data levels, the data-line enable, busy and done
// flags, the last read byte and the last acknowledge. A tick is taken every clock
// cycle; its result sits in the output register from the cycle after the tick is
// accepted, and tick.ready stays high while that register is empty or being
// drained, so a stalled result only holds off the next tick. Pin phases last
// phase_ticks ticks (register 0) and the acknowledge clock-high lasts
// ack_wait_ticks ticks (register 1); a zero in either acts as one. Commands that
// arrive while a sequence runs are ignored.
module sccb_bit_master_unit (
	input  logic          clk,
	input  logic          arst_n,
	sbm_tick_if.sink      tick,
	sbm_result_if.source  result,
	sbm_cfg_if.sink       cfg
);

	sbm_pkg::waits_t waits;
	sbm_pkg::res_t   res;
	sbm_pkg::res_t   res_q;
	logic            out_valid_q;
	logic            accept;

	sbm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.waits  (waits)
	);

	// tick taken while the output register is free or being drained
	assign tick.ready = !out_valid_q || result.ready;
	assign accept     = tick.valid && tick.ready;

	sbm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cmd     (tick.cmd),
		.tx_byte (tick.tx_byte),
		.sda_in  (tick.sda_in),
		.waits   (waits),
		.res     (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) res_q <= res;
	end

	assign result.valid    = out_valid_q;
	assign result.scl      = res_q.scl;
	assign result.sda_out  = res_q.sda_out;
	assign result.sda_oe   = res_q.sda_oe;
	assign result.busy_res = res_q.busy_res;
	assign result.done_res = res_q.done_res;
	assign result.rx_byte  = res_q.rx_byte;
	assign result.acked    = res_q.acked;

	// a completing tick never reports busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.done_res |-> !result.busy_res)
		else $error("done beat reports busy");

	// every accepted tick leaves a result beat behind
	a_tick_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result.valid)
		else $error("accepted tick without result beat");

endmodule

### hw/rtl/sbm_cfg.sv
module sbm_cfg (
	input  logic            clk,
	input  logic            arst_n,
	sbm_cfg_if.sink         cfg,
	output sbm_pkg::waits_t waits
);

	logic [sbm_pkg::TICK_W-1:0] phase_q;
	logic [sbm_pkg::TICK_W-1:0] ack_q;

	assign cfg.ready = 1'b1;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sbm_pkg::PHASE_TICKS_RST;
			ack_q   <= sbm_pkg::ACK_TICKS_RST;
		end else if (cfg.valid) begin
			if (cfg.index == sbm_pkg::REG_PHASE_TICKS) phase_q <= cfg.data;
			if (cfg.index == sbm_pkg::REG_ACK_TICKS) ack_q <= cfg.data;
		end
	end

	// a zero length counts as one tick
	assign waits.phase = (phase_q == '0) ? sbm_pkg::TICK_W'(1) : phase_q;
	assign waits.ack   = (ack_q == '0) ? sbm_pkg::TICK_W'(1) : ack_q;

endmodule

### hw/rtl/sbm_core.sv
module sbm_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [2:0]                       cmd,
	input  logic [sbm_pkg::BITS_PER_BYTE-1:0] tx_byte,
	input  logic                             sda_in,
	input  sbm_pkg::waits_t                  waits,
	output sbm_pkg::res_t                    res
);

	localparam logic [sbm_pkg::BIT_IDX_W-1:0] NBITS =
		sbm_pkg::BIT_IDX_W'(sbm_pkg::BITS_PER_BYTE);
	localparam int MSB = sbm_pkg::BITS_PER_BYTE - 1;

	sbm_pkg::state_t            st_q;
	sbm_pkg::state_t            cand;
	sbm_pkg::state_t            nx;
	logic [sbm_pkg::TICK_W-1:0] dly_q;
	logic [sbm_pkg::TICK_W-1:0] dec;
	logic [sbm_pkg::TICK_W-1:0] w;
	logic [sbm_pkg::TICK_W-1:0] nx_dly;
	logic                       do_enter;
	logic                       fin;

	// pick the next action: start a command or advance the running one
	always_comb begin
		cand     = st_q;
		do_enter = 1'b0;
		fin      = 1'b0;
		dec      = (dly_q != '0) ? dly_q - sbm_pkg::TICK_W'(1) : '0;
		if (st_q.op == sbm_pkg::OP_IDLE) begin
			if (cmd >= sbm_pkg::OP_START && cmd <= sbm_pkg::OP_READ) begin
				cand.op      = sbm_pkg::op_t'(cmd);
				cand.step    = '0;
				cand.bit_idx = '0;
				if (cmd == sbm_pkg::OP_WRITE) cand.shreg = tx_byte;
				if (cmd == sbm_pkg::OP_READ) cand.rbyte = '0;
				do_enter = 1'b1;
			end
		end else begin
			if (dec == '0) begin
				unique case (st_q.op)
					sbm_pkg::OP_START, sbm_pkg::OP_NOACK: begin
						cand.step = st_q.step + 1'b1;
						do_enter  = (st_q.step < 3'd3);
					end
					sbm_pkg::OP_STOP: begin
						cand.step = st_q.step + 1'b1;
						do_enter  = (st_q.step < 3'd2);
					end
					sbm_pkg::OP_WRITE: begin
						if (st_q.bit_idx < NBITS) begin
							if (st_q.step < 3'd2) begin
								cand.step = st_q.step + 1'b1;
							end else begin
								cand.step    = '0;
								cand.bit_idx = st_q.bit_idx + 1'b1;
								cand.shreg   = {st_q.shreg[MSB-1:0], 1'b0};
							end
							do_enter = 1'b1;
						end else begin
							cand.step = st_q.step + 1'b1;
							do_enter  = (st_q.step < 3'd4);
						end
					end
					sbm_pkg::OP_READ: begin
						if (st_q.step < 3'd3) begin
							cand.step = st_q.step + 1'b1;
							do_enter  = 1'b1;
						end else begin
							cand.bit_idx = st_q.bit_idx + 1'b1;
							cand.step    = 3'd1;
							do_enter     = (cand.bit_idx < NBITS);
						end
					end
					default: do_enter = 1'b0;
				endcase
				fin = !do_enter;
			end
		end
	end

	// apply the pin action of the chosen step and load its wait
	always_comb begin
		nx     = cand;
		w      = waits.phase;
		nx_dly = (st_q.op == sbm_pkg::OP_IDLE) ? dly_q : dec;
		if (do_enter) begin
			unique case (cand.op)
				sbm_pkg::OP_START: begin
					unique case (cand.step)
						3'd0:    nx.sda = 1'b1;
						3'd1:    nx.scl = 1'b1;
						3'd2:    nx.sda = 1'b0;
						default: nx.scl = 1'b0;
					endcase
				end
				sbm_pkg::OP_STOP: begin
					unique case (cand.step)
						3'd0:    nx.sda = 1'b0;
						3'd1:    nx.scl = 1'b1;
						default: nx.sda = 1'b1;
					endcase
				end
				sbm_pkg::OP_NOACK: begin
					unique case (cand.step)
						3'd0:    nx.sda = 1'b1;
						3'd1:    nx.scl = 1'b1;
						3'd2:    nx.scl = 1'b0;
						default: nx.sda = 1'b0;
					endcase
				end
				sbm_pkg::OP_WRITE: begin
					if (cand.bit_idx < NBITS) begin
						unique case (cand.step)
							3'd0:    nx.sda = cand.shreg[MSB];
							3'd1:    nx.scl = 1'b1;
							default: nx.scl = 1'b0;
						endcase
					end else begin
						// acknowledge slot after the eighth bit
						unique case (cand.step)
							3'd0: ;
							3'd1: nx.oe = 1'b0;
							3'd2: begin
								nx.scl = 1'b1;
								w      = waits.ack;
							end
							3'd3: begin
								nx.ack = !sda_in;
								nx.scl = 1'b0;
							end
							default: begin
								nx.oe = 1'b1;
								w     = '0;
							end
						endcase
					end
				end
				sbm_pkg::OP_READ: begin
					if (cand.step == 3'd0) begin
						nx.oe = 1'b0;
					end else if (cand.step == 3'd2) begin
						nx.scl = 1'b1;
					end else if (cand.step >= 3'd3) begin
						nx.rbyte = {cand.rbyte[MSB-1:0], sda_in};
						nx.scl   = 1'b0;
					end
				end
				default: w = '0;
			endcase
			nx_dly = w;
		end
		// sequence end
		if (fin || (do_enter && w == '0)) begin
			nx.op      = sbm_pkg::OP_IDLE;
			nx.step    = '0;
			nx.bit_idx = '0;
			nx_dly     = '0;
		end
	end

	// sequencer registers advance once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{op: sbm_pkg::OP_IDLE, step: '0, bit_idx: '0, shreg: '0,
				scl: 1'b1, sda: 1'b1, oe: 1'b1, ack: 1'b0, rbyte: '0};
			dly_q <= '0;
		end else if (accept) begin
			st_q  <= nx;
			dly_q <= nx_dly;
		end
	end

	// result of this tick, taken after the update
	always_comb begin
		res.scl      = nx.scl;
		res.sda_out  = nx.sda;
		res.sda_oe   = nx.oe;
		res.busy_res = (nx.op != sbm_pkg::OP_IDLE);
		res.done_res = fin || (do_enter && w == '0);
		res.rx_byte  = nx.rbyte;
		res.acked    = nx.ack;
	end

	// a running command is never replaced by another
	a_no_preempt: assert property (@(posedge clk) disable iff (!arst_n)
		accept && st_q.op != sbm_pkg::OP_IDLE |=>
			st_q.op == $past(st_q.op) || st_q.op == sbm_pkg::OP_IDLE)
		else $error("running command replaced");

	// a read keeps the data line released
	a_read_released: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.op == sbm_pkg::OP_READ |-> !st_q.oe)
		else $error("data line driven during read");

	// no pending wait while idle, bit counter in range
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.op == sbm_pkg::OP_IDLE |-> dly_q == '0 && st_q.bit_idx == '0)
		else $error("idle with pending wait or bit count");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bit_idx <= NBITS)
		else $error("bit index out of range");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

	// command codes outside the defined set, the block must ignore them
	localparam logic [2:0] CODE_SPARE6 = 3'd6;
	localparam logic [2:0] CODE_SPARE7 = 3'd7;

	localparam int ITEM_TARGET = 1950;

	// pin states that can be read straight off the reset values
	localparam sbm_pkg::res_t IDLE_OUT = '{scl: 1'b1, sda_out: 1'b1, sda_oe: 1'b1,
		busy_res: 1'b0, done_res: 1'b0, rx_byte: 8'h00, acked: 1'b0};
	localparam sbm_pkg::res_t START_OUT = '{scl: 1'b1, sda_out: 1'b1, sda_oe: 1'b1,
		busy_res: 1'b1, done_res: 1'b0, rx_byte: 8'h00, acked: 1'b0};

	// one directed bus command, optionally preceded by new wait settings
	typedef struct {
		logic [2:0]    cmd;
		logic [7:0]    tx;
		logic [7:0]    line;
		bit            reconf;
		logic [15:0]   phase;
		logic [15:0]   ackw;
		bit            typed;
		sbm_pkg::res_t want;
	} bus_row_t;

	logic clk;
	logic arst_n;

	sbm_tick_if   tick_bus();
	sbm_result_if res_bus();
	sbm_cfg_if    cfg_bus();

	sccb_bit_master_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_bus.sink),
		.result (res_bus.source),
		.cfg    (cfg_bus.sink)
	);

	// expected pin states, oldest first
	sbm_pkg::res_t pin_state_q[$];
	int   fail_count;
	int   items_sent;
	bit   throttle_on;
	int unsigned burst_left;
	int unsigned flow_left;
	int unsigned stall_left;
	bus_row_t plan[$];

	// bus sequencer mirror
	logic [15:0]  cfg_phase;
	logic [15:0]  cfg_ack;
	sbm_pkg::op_t bus_op;
	logic [2:0]   bus_step;
	logic [3:0]   bus_bit;
	logic [15:0]  wait_left;
	logic [7:0]   tx_shift;
	logic         pin_scl;
	logic         pin_sda;
	logic         pin_oe;
	logic         ack_seen;
	logic [7:0]   rx_acc;

	always #5 clk = ~clk;

	// apply the pin action of the current step, return its wait (0 ends the command)
	function automatic logic [15:0] apply_step(input logic sda);
		logic [15:0] phase_w;
		logic [15:0] ack_w;
		phase_w = (cfg_phase == 16'd0) ? 16'd1 : cfg_phase;
		ack_w = (cfg_ack == 16'd0) ? 16'd1 : cfg_ack;
		case (bus_op)
		sbm_pkg::OP_START: begin
			case (bus_step)
			3'd0: pin_sda = 1'b1;
			3'd1: pin_scl = 1'b1;
			3'd2: pin_sda = 1'b0;
			default: pin_scl = 1'b0;
			endcase
			return phase_w;
		end
		sbm_pkg::OP_STOP: begin
			case (bus_step)
			3'd0: pin_sda = 1'b0;
			3'd1: pin_scl = 1'b1;
			default: pin_sda = 1'b1;
			endcase
			return phase_w;
		end
		sbm_pkg::OP_NOACK: begin
			case (bus_step)
			3'd0: pin_sda = 1'b1;
			3'd1: pin_scl = 1'b1;
			3'd2: pin_scl = 1'b0;
			default: pin_sda = 1'b0;
			endcase
			return phase_w;
		end
		sbm_pkg::OP_WRITE: begin
			if (bus_bit < sbm_pkg::BITS_PER_BYTE) begin
				case (bus_step)
				3'd0: pin_sda = tx_shift[7];
				3'd1: pin_scl = 1'b1;
				default: pin_scl = 1'b0;
				endcase
				return phase_w;
			end
			case (bus_step)
			3'd0: return phase_w;
			3'd1: begin
				pin_oe = 1'b0;
				return phase_w;
			end
			3'd2: begin
				pin_scl = 1'b1;
				return ack_w;
			end
			3'd3: begin
				// low line at the acknowledge sample means acknowledged
				ack_seen = ~sda;
				pin_scl = 1'b0;
				return phase_w;
			end
			default: begin
				pin_oe = 1'b1;
				return 16'd0;
			end
			endcase
		end
		sbm_pkg::OP_READ: begin
			if (bus_step == 3'd0) begin
				pin_oe = 1'b0;
			end else if (bus_step == 3'd2) begin
				pin_scl = 1'b1;
			end else if (bus_step >= 3'd3) begin
				rx_acc = {rx_acc[6:0], sda};
				pin_scl = 1'b0;
			end
			return phase_w;
		end
		default: return 16'd0;
		endcase
	endfunction

	// move to the next step, 0 when the sequence is over
	function automatic bit advance_step();
		case (bus_op)
		sbm_pkg::OP_START, sbm_pkg::OP_NOACK: begin
			bus_step++;
			return bus_step <= 3'd3;
		end
		sbm_pkg::OP_STOP: begin
			bus_step++;
			return bus_step <= 3'd2;
		end
		sbm_pkg::OP_WRITE: begin
			if (bus_bit < sbm_pkg::BITS_PER_BYTE) begin
				if (bus_step < 3'd2) begin
					bus_step++;
				end else begin
					bus_step = 3'd0;
					bus_bit++;
					tx_shift = {tx_shift[6:0], 1'b0};
				end
				return 1'b1;
			end
			if (bus_step >= 3'd4) return 1'b0;
			bus_step++;
			return 1'b1;
		end
		sbm_pkg::OP_READ: begin
			if (bus_step < 3'd3) begin
				bus_step++;
				return 1'b1;
			end
			bus_bit++;
			if (bus_bit >= sbm_pkg::BITS_PER_BYTE) return 1'b0;
			bus_step = 3'd1;
			return 1'b1;
		end
		default: return 1'b0;
		endcase
	endfunction

	// one time tick of the bus sequencer, returns the pin state after it
	function automatic sbm_pkg::res_t predict_tick(input logic [2:0] cmd, input logic [7:0] tx,
			input logic sda);
		logic [15:0] next_wait;
		sbm_pkg::res_t r;
		r.done_res = 1'b0;
		if (bus_op == sbm_pkg::OP_IDLE) begin
			if (cmd >= sbm_pkg::OP_START && cmd <= sbm_pkg::OP_READ) begin
				bus_op = sbm_pkg::op_t'(cmd);
				bus_step = 3'd0;
				bus_bit = 4'd0;
				if (bus_op == sbm_pkg::OP_WRITE) tx_shift = tx;
				if (bus_op == sbm_pkg::OP_READ) rx_acc = 8'h00;
				wait_left = apply_step(sda);
			end
		end else begin
			if (wait_left != 16'd0) wait_left--;
			if (wait_left == 16'd0) begin
				next_wait = 16'd0;
				if (advance_step()) next_wait = apply_step(sda);
				if (next_wait == 16'd0) begin
					bus_op = sbm_pkg::OP_IDLE;
					bus_step = 3'd0;
					bus_bit = 4'd0;
					r.done_res = 1'b1;
				end
				wait_left = next_wait;
			end
		end
		r.scl = pin_scl;
		r.sda_out = pin_sda;
		r.sda_oe = pin_oe;
		r.busy_res = (bus_op != sbm_pkg::OP_IDLE);
		r.rx_byte = rx_acc;
		r.acked = ack_seen;
		return r;
	endfunction

	// present one tick beat, with burst pacing on the sender side
	task automatic send_tick(input logic [2:0] cmd, input logic [7:0] tx, input logic sda,
			input bit typed, input sbm_pkg::res_t want);
		sbm_pkg::res_t pred;
		if (throttle_on && burst_left == 0) begin
			tick_bus.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 24);
		end
		if (burst_left != 0) burst_left--;
		tick_bus.valid = 1'b1;
		tick_bus.cmd = cmd;
		tick_bus.tx_byte = tx;
		tick_bus.sda_in = sda;
		do @(posedge clk); while (!tick_bus.ready);
		pred = predict_tick(cmd, tx, sda);
		pin_state_q.push_back(typed ? want : pred);
		items_sent++;
		@(negedge clk);
	endtask

	// issue a command and clock ticks until it completes; line holds the levels
	// the slave puts on the data line (read bits msb first, bit 0 for the ack)
	task automatic run_cmd(input logic [2:0] cmd, input logic [7:0] tx, input logic [7:0] line,
			input bit typed, input sbm_pkg::res_t want);
		logic [2:0] noise;
		logic sda;
		send_tick(cmd, tx, 1'($urandom_range(0, 1)), typed, want);
		while (bus_op != sbm_pkg::OP_IDLE) begin
			noise = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : sbm_pkg::OP_IDLE;
			sda = (bus_op == sbm_pkg::OP_READ) ? line[7 - bus_bit] : line[0];
			send_tick(noise, 8'($urandom), sda, 1'b0, '0);
		end
	endtask

	// write both wait registers once every result is in
	task automatic set_waits(input logic [15:0] phase, input logic [15:0] ackw);
		tick_bus.valid = 1'b0;
		while (pin_state_q.size() != 0) @(negedge clk);
		for (int r = 0; r < 2; r++) begin
			cfg_bus.valid = 1'b1;
			cfg_bus.index = (r == 0) ? sbm_pkg::REG_PHASE_TICKS : sbm_pkg::REG_ACK_TICKS;
			cfg_bus.data = (r == 0) ? phase : ackw;
			do @(posedge clk); while (!cfg_bus.ready);
			if (cfg_bus.index == sbm_pkg::REG_PHASE_TICKS) cfg_phase = cfg_bus.data;
			else cfg_ack = cfg_bus.data;
			@(negedge clk);
		end
		cfg_bus.valid = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// receiver stall pattern: runs of ready with short stalls between when throttling
	always @(negedge clk) begin
		if (flow_left != 0) begin
			flow_left <= flow_left - 1;
			res_bus.ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_bus.ready <= !throttle_on;
		end else begin
			flow_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
				: $urandom_range(1, 8);
			stall_left <= $urandom_range(1, 3);
			res_bus.ready <= 1'b1;
		end
	end

	// compare each result beat with the oldest expected pin state
	sbm_pkg::res_t head;
	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pin_state_q.size() == 0) begin
				$display("%0t: result beat with nothing expected", $time);
				fail_count++;
			end else begin
				head = pin_state_q.pop_front();
				check_field("scl", 8'(head.scl), 8'(res_bus.scl));
				check_field("sda_out", 8'(head.sda_out), 8'(res_bus.sda_out));
				check_field("sda_oe", 8'(head.sda_oe), 8'(res_bus.sda_oe));
				check_field("busy_res", 8'(head.busy_res), 8'(res_bus.busy_res));
				check_field("done_res", 8'(head.done_res), 8'(res_bus.done_res));
				check_field("rx_byte", head.rx_byte, res_bus.rx_byte);
				check_field("acked", 8'(head.acked), 8'(res_bus.acked));
			end
		end
	end

	initial begin
		#40_000_000;
		$display("** sccb_bit_master_unit: FAILED **");
		$finish;
	end

	initial begin
		bus_row_t row;
		int reads;
		int drain_wait;
		clk = 1'b0;
		arst_n = 1'b0;
		tick_bus.valid = 1'b0;
		tick_bus.cmd = sbm_pkg::OP_IDLE;
		tick_bus.tx_byte = 8'h00;
		tick_bus.sda_in = 1'b1;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = sbm_pkg::REG_PHASE_TICKS;
		cfg_bus.data = 16'd0;
		res_bus.ready = 1'b0;
		fail_count = 0;
		items_sent = 0;
		throttle_on = 1'b1;
		burst_left = 0;
		cfg_phase = sbm_pkg::PHASE_TICKS_RST;
		cfg_ack = sbm_pkg::ACK_TICKS_RST;
		bus_op = sbm_pkg::OP_IDLE;
		bus_step = 3'd0;
		bus_bit = 4'd0;
		wait_left = 16'd0;
		tx_shift = 8'h00;
		pin_scl = 1'b1;
		pin_sda = 1'b1;
		pin_oe = 1'b1;
		ack_seen = 1'b0;
		rx_acc = 8'h00;

		// directed commands: reset state, spare codes, every command, ack both ways,
		// zero waits, reads that leave the line released
		plan.push_back('{sbm_pkg::OP_IDLE, 8'h00, 8'h00, 1'b0, 16'd0, 16'd0, 1'b1, IDLE_OUT});
		plan.push_back('{CODE_SPARE6, 8'hFF, 8'h00, 1'b0, 16'd0, 16'd0, 1'b1, IDLE_OUT});
		plan.push_back('{CODE_SPARE7, 8'h00, 8'h00, 1'b0, 16'd0, 16'd0, 1'b1, IDLE_OUT});
		plan.push_back('{sbm_pkg::OP_START, 8'h00, 8'h00, 1'b0, 16'd0, 16'd0, 1'b1, START_OUT});
		plan.push_back('{sbm_pkg::OP_WRITE, 8'hFF, 8'h00, 1'b1, 16'd0, 16'd0, 1'b0, '0});
		plan.push_back('{sbm_pkg::OP_WRITE, 8'h00, 8'hFF, 1'b0, 16'd0, 16'd0, 1'b0, '0});
		plan.push_back('{sbm_pkg::OP_WRITE, 8'hA5, 8'h00, 1'b1, 16'd1, 16'd1, 1'b0, '0});
		plan.push_back('{sbm_pkg::OP_READ, 8'h00, 8'hFF, 1'b0, 16'd0, 16'd0, 1'b0, '0});
		plan.push_back('{sbm_pkg::OP_NOACK, 8'h00, 8'h00, 1'b0, 16'd0, 16'd0, 1'b0, '0});
		plan.push_back('{sbm_pkg::OP_READ, 8'hFF, 8'h00, 1'b0, 16'd0, 16'd0, 1'b0, '0});
		plan.push_back('{sbm_pkg::OP_NOACK, 8'h00, 8'h00, 1'b0, 16'd0, 16'd0, 1'b0, '0});
		plan.push_back('{sbm_pkg::OP_STOP, 8'h00, 8'h00, 1'b0, 16'd0, 16'd0, 1'b0, '0});
		plan.push_back('{sbm_pkg::OP_START, 8'h00, 8'h00, 1'b1, 16'd2, 16'd3, 1'b0, '0});
		plan.push_back('{sbm_pkg::OP_READ, 8'h00, 8'h5A, 1'b0, 16'd0, 16'd0, 1'b0, '0});
		plan.push_back('{sbm_pkg::OP_STOP, 8'h00, 8'h00, 1'b0, 16'd0, 16'd0, 1'b0, '0});
		plan.push_back('{sbm_pkg::OP_START, 8'h00, 8'h00, 1'b0, 16'd0, 16'd0, 1'b0, '0});
		plan.push_back('{sbm_pkg::OP_WRITE, 8'h3C, 8'h01, 1'b0, 16'd0, 16'd0, 1'b0, '0});
		plan.push_back('{sbm_pkg::OP_STOP, 8'h00, 8'h00, 1'b0, 16'd0, 16'd0, 1'b0, '0});
		plan.push_back('{sbm_pkg::OP_READ, 8'h00, 8'hA3, 1'b0, 16'd0, 16'd0, 1'b0, '0});
		plan.push_back('{sbm_pkg::OP_NOACK, 8'h00, 8'h00, 1'b0, 16'd0, 16'd0, 1'b0, '0});

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			if (row.reconf) set_waits(row.phase, row.ackw);
			run_cmd(row.cmd, row.tx, row.line, row.typed, row.want);
		end

		// random bus transfers under short wait settings
		while (items_sent < ITEM_TARGET) begin
			set_waits(16'($urandom_range(0, 3)), 16'($urandom_range(0, 6)));
			throttle_on = ($urandom_range(0, 4) != 0);
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 6) != 0) begin
					// start, writes, reads each closed by a no-ack, stop
					run_cmd(sbm_pkg::OP_START, 8'($urandom), 8'($urandom), 1'b0, '0);
					repeat ($urandom_range(1, 3))
						run_cmd(sbm_pkg::OP_WRITE, 8'($urandom), 8'($urandom), 1'b0, '0);
					reads = $urandom_range(0, 2);
					repeat (reads) begin
						run_cmd(sbm_pkg::OP_READ, 8'($urandom), 8'($urandom), 1'b0, '0);
						run_cmd(sbm_pkg::OP_NOACK, 8'($urandom), 8'($urandom), 1'b0, '0);
					end
					run_cmd(sbm_pkg::OP_STOP, 8'($urandom), 8'($urandom), 1'b0, '0);
				end else begin
					// stray command out of sequence
					run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 1'b0, '0);
				end
				repeat ($urandom_range(0, 2))
					send_tick(($urandom_range(0, 1) == 0) ? sbm_pkg::OP_IDLE : CODE_SPARE7,
						8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
			end
		end

		throttle_on = 1'b1;
		set_waits(16'd1, 16'd1);
		run_cmd(sbm_pkg::OP_READ, 8'h00, 8'h69, 1'b0, '0);

		// longest acknowledge wait: the clock stays high well past the window checked
		throttle_on = 1'b0;
		set_waits(16'd1, 16'hFFFF);
		send_tick(sbm_pkg::OP_WRITE, 8'h96, 1'b0, 1'b0, '0);
		repeat (60) send_tick(sbm_pkg::OP_IDLE, 8'h00, 1'b0, 1'b0, '0);

		// drain the remaining results
		tick_bus.valid = 1'b0;
		drain_wait = 0;
		while (pin_state_q.size() != 0 && drain_wait < 1000) begin
			@(negedge clk);
			drain_wait++;
		end
		repeat (4) @(negedge clk);
		if (pin_state_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pin_state_q.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("** sccb_bit_master_unit: PASSED **");
		end else begin
			$display("** sccb_bit_master_unit: FAILED **");
		end
		$finish;
	end

endmodule

### sccb_bit_master_unit.f
hw/rtl/sbm_pkg.sv
hw/rtl/sbm_tick_if.sv
hw/rtl/sbm_result_if.sv
hw/rtl/sbm_cfg_if.sv
hw/rtl/sbm_cfg.sv
hw/rtl/sbm_core.sv
hw/rtl/sccb_bit_master_unit.sv
bench/tb.sv
